// ----- hdl/seek_table_planner_macros.svh -----
`ifndef SEEK_TABLE_PLANNER_MACROS_SVH
`define SEEK_TABLE_PLANNER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SKP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SKP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/skp_pkg.sv -----
`default_nettype none

package skp_pkg;

	localparam int TABLE_DEPTH_DEF = 4096;
	localparam int POS_W           = 32;
	localparam int FRAME_W         = 31;
	localparam int CMD_W           = 2;
	localparam int STATUS_W        = 2;
	localparam int START_W         = 12;
	localparam int PRE_W           = 3;
	localparam int DIV_W           = 32;
	localparam int DIV_CNT_W       = $clog2(DIV_W);

	localparam int MIN_RESUME_IDX  = 5;
	localparam int PREROLL         = 4;

	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SEEK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ----- hdl/skp_div.sv -----
`default_nettype none

module skp_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [skp_pkg::DIV_W-1:0] dividend,
	input  wire logic [skp_pkg::DIV_W-1:0] divisor,
	output logic      [skp_pkg::DIV_W-1:0] quotient,
	output skp_pkg::div_stat_t             stat
);
	import skp_pkg::*;

	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       rem_sh;
	logic [DIV_W:0]       diff;

	// restoring divide, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign diff   = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ----- hdl/skp_mem.sv -----
`default_nettype none

module skp_mem #(
	parameter int DEPTH = skp_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [skp_pkg::POS_W-1:0] wdata,
	input  wire logic [AW-1:0]             raddr,
	output logic      [skp_pkg::POS_W-1:0] rdata
);
	import skp_pkg::*;

	logic [POS_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/seek_table_planner.sv -----
`default_nettype none

// Seek table planner. Commands arrive one beat at a time on the input channel and each
// produces exactly one result beat. Append, clear and the unused code pass through dispatch,
// result hand-off and the idle state that accepts the next command. A seek adds the serial
// divide of target by avg_frame_size (skipped when that register is zero, the target is zero
// or the table is empty), the table reads of the down and up walks, a turn from the down walk
// to the up walk, and the fetch of the chosen entry, entry 0 or both; the walk length depends
// on how far the guess lands from the target. Each entry read takes a read state and a check
// state, as the position table has a single read port. The input channel is not ready while
// a command is in progress; a finished result waits in the output register while the next
// command is accepted. avg_frame_size is written through the cfg channel, which is always ready.
module seek_table_planner #(
	parameter int TABLE_DEPTH = skp_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [skp_pkg::POS_W-1:0]    cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [skp_pkg::CMD_W-1:0]    cmd,
	input  wire logic [skp_pkg::POS_W-1:0]    entry_pos,
	input  wire logic [skp_pkg::FRAME_W-1:0]  frame_number,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [skp_pkg::STATUS_W-1:0] status,
	output logic      [skp_pkg::POS_W-1:0]    found_pos,
	output logic      [skp_pkg::START_W-1:0]  start_index,
	output logic      [skp_pkg::PRE_W-1:0]    preroll_frames,
	output logic                              restart,
	output logic      [skp_pkg::POS_W-1:0]    discard_count
);
	import skp_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_DN_RD = 4'd3;
	localparam logic [3:0] S_DN_CK = 4'd4;
	localparam logic [3:0] S_UP_RD = 4'd5;
	localparam logic [3:0] S_UP_CK = 4'd6;
	localparam logic [3:0] S_F_RD  = 4'd7;
	localparam logic [3:0] S_F_CK  = 4'd8;
	localparam logic [3:0] S_Z_RD  = 4'd9;
	localparam logic [3:0] S_Z_CK  = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0]          state_q;
	logic [POS_W-1:0]    avg_q;
	logic [CW-1:0]       count_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    target_q;
	logic [AW-1:0]       idx_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [POS_W-1:0]    res_found_q;
	logic [START_W-1:0]  res_start_q;
	logic [PRE_W-1:0]    res_pre_q;
	logic                res_restart_q;
	logic [POS_W-1:0]    res_disc_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]    found_q;
	logic [START_W-1:0]  start_q;
	logic [PRE_W-1:0]    pre_q;
	logic                restart_q;
	logic [POS_W-1:0]    disc_q;

	logic                div_start;
	logic [DIV_W-1:0]    div_quo;
	div_stat_t           div_st;
	logic                mem_we;
	logic [POS_W-1:0]    rdata;
	logic [CW-1:0]       cap;
	logic [AW-1:0]       guess;
	logic                idx_is_cap;
	logic                idx_is_zero;
	logic [POS_W-1:0]    disc_from;
	logic [POS_W-1:0]    idx_wide;
	logic                in_acc;
	logic                out_free;

	assign in_acc      = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign cap         = count_q - 1'b1;
	assign guess       = (div_quo > POS_W'(cap)) ? cap[AW-1:0] : div_quo[AW-1:0];
	assign idx_is_cap  = (CW'(idx_q) == cap);
	assign idx_is_zero = (idx_q == '0);
	assign idx_wide    = POS_W'(idx_q);
	assign disc_from   = (target_q > rdata) ? target_q - rdata : '0;
	assign div_start   = (state_q == S_DISP) && (cmd_q == CMD_SEEK) && (count_q != '0)
		&& (target_q != '0) && (avg_q != '0);
	assign mem_we      = (state_q == S_DISP) && (cmd_q == CMD_APPEND)
		&& (count_q < CW'(TABLE_DEPTH));

	skp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (target_q),
		.divisor  (avg_q),
		.quotient (div_quo),
		.stat     (div_st)
	);

	skp_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata (pos_q),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			avg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					unique case (cmd_q)
						CMD_APPEND: begin
							state_q <= S_DONE;
							if (mem_we) begin
								count_q <= count_q + 1'b1;
							end
						end
						CMD_CLEAR: begin
							state_q <= S_DONE;
							count_q <= '0;
						end
						CMD_SEEK: begin
							if (div_start) begin
								state_q <= S_DIV;
							end else if (count_q != '0 && target_q != '0) begin
								state_q <= S_DN_RD;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_DIV: begin
					if (div_st.done) begin
						state_q <= S_DN_RD;
					end
				end
				S_DN_RD: state_q <= S_DN_CK;
				S_DN_CK: begin
					priority if (rdata > target_q && idx_is_zero) begin
						state_q <= S_Z_RD;
					end else if (rdata > target_q) begin
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_UP_CK;
					end
				end
				S_UP_RD: state_q <= S_UP_CK;
				S_UP_CK: begin
					priority if (rdata < target_q && idx_is_cap) begin
						state_q <= S_F_RD;
					end else if (rdata < target_q) begin
						state_q <= S_UP_RD;
					end else if (idx_is_zero) begin
						state_q <= S_Z_RD;
					end else begin
						state_q <= S_F_RD;
					end
				end
				S_F_RD: state_q <= S_F_CK;
				S_F_CK: begin
					if (idx_wide < POS_W'(MIN_RESUME_IDX) || rdata == '0
						|| rdata > target_q) begin
						state_q <= S_Z_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_Z_RD: state_q <= S_Z_CK;
				S_Z_CK: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q         <= cmd;
			pos_q         <= entry_pos;
			target_q      <= {frame_number, 1'b0};
			idx_q         <= '0;
			res_status_q  <= ST_OK;
			res_found_q   <= '0;
			res_start_q   <= '0;
			res_pre_q     <= '0;
			res_restart_q <= 1'b0;
			res_disc_q    <= '0;
		end else begin
			unique case (state_q)
				S_DISP: begin
					if (cmd_q == CMD_APPEND && !mem_we) begin
						res_status_q <= ST_FULL;
					end
					if (cmd_q == CMD_SEEK && count_q == '0) begin
						res_status_q <= ST_EMPTY;
					end else if (cmd_q == CMD_SEEK && target_q == '0) begin
						res_restart_q <= 1'b1;
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						idx_q <= guess;
					end
				end
				S_DN_CK: begin
					if (rdata > target_q && !idx_is_zero) begin
						idx_q <= idx_q - 1'b1;
					end
				end
				S_UP_CK: begin
					priority if (rdata < target_q && !idx_is_cap) begin
						idx_q <= idx_q + 1'b1;
					end else if (rdata >= target_q && !idx_is_zero) begin
						idx_q <= idx_q - 1'b1;
					end else begin
						idx_q <= idx_q;
					end
				end
				S_F_CK: begin
					res_found_q <= rdata;
					if (idx_wide < POS_W'(MIN_RESUME_IDX) || rdata == '0
						|| rdata > target_q) begin
						res_restart_q <= 1'b1;
						idx_q         <= '0;
					end else begin
						res_start_q <= START_W'(idx_wide - POS_W'(PREROLL));
						res_pre_q   <= PRE_W'(PREROLL);
						res_disc_q  <= disc_from;
					end
				end
				S_Z_RD: res_restart_q <= 1'b1;
				S_Z_CK: res_disc_q <= disc_from;
				default: idx_q <= idx_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q  <= res_status_q;
			found_q   <= res_found_q;
			start_q   <= res_start_q;
			pre_q     <= res_pre_q;
			restart_q <= res_restart_q;
			disc_q    <= res_disc_q;
		end
	end

	assign cfg_ready      = 1'b1;
	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_pos      = found_q;
	assign start_index    = start_q;
	assign preroll_frames = pre_q;
	assign restart        = restart_q;
	assign discard_count  = disc_q;

`include "seek_table_planner_macros.svh"

	`SKP_ASSERT_NOW(a_pre_excl, out_valid && preroll_frames != '0,
		!restart && preroll_frames == PRE_W'(PREROLL), "preroll beat with restart set")
	`SKP_ASSERT_NOW(a_rst_start, out_valid && restart,
		start_index == '0 && preroll_frames == '0, "restart beat with resume fields")
	`SKP_ASSERT_NXT(a_append_cnt, mem_we, count_q == $past(count_q) + 1'b1,
		"entry count did not advance on append")
	`SKP_ASSERT_NOW(a_div_seek, div_st.busy || div_st.done, state_q == S_DIV,
		"divider running outside a seek")

endmodule

`default_nettype wire
